FILE: hw/rtl/websocket_frame_deframer_assert.svh
// ----------------------------------------------------------------------------
// WebSocket frame deframer assertion macros
// Concurrent assertion wrappers shared by the deframer RTL files.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising edge of clk outside reset.
`define WSFD_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("wsfd assertion failed");
// Checked on every rising edge of clk, also during reset.
`define WSFD_ASSERT_ALWAYS(name, prop) \
	name: assert property (@(posedge clk) prop) \
	else $error("wsfd assertion failed");
`else
`define WSFD_ASSERT(name, prop)
`define WSFD_ASSERT_ALWAYS(name, prop)
`endif

`endif

FILE: hw/rtl/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Result type, result kinds, error codes and header constants.
// ----------------------------------------------------------------------------
package wsfd_pkg;

	localparam int FRAME_LEN_W = 17;

	// Result kinds.
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_BYTE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Error codes.
	localparam logic [1:0] ERR_RSV      = 2'd0;
	localparam logic [1:0] ERR_FIN      = 2'd1;
	localparam logic [1:0] ERR_LONG     = 2'd2;
	localparam logic [1:0] ERR_UNMASKED = 2'd3;

	// Header fields.
	localparam logic [7:0] HDR_RSV_MASK  = 8'h70;
	localparam logic [7:0] HDR_FIN_MASK  = 8'h80;
	localparam logic [7:0] HDR_OP_MASK   = 8'h0f;
	localparam logic [7:0] HDR_LEN_MASK  = 8'h7f;
	localparam logic [6:0] LEN7_EXT16    = 7'd126;
	localparam logic [6:0] LEN7_EXT64    = 7'd127;
	localparam logic [3:0] EXT16_BYTES   = 4'd2;
	localparam logic [3:0] EXT64_BYTES   = 4'd8;
	localparam logic [3:0] KEY_BYTES     = 4'd4;

	// Configuration register map.
	localparam logic                   REG_MAX_PAYLOAD   = 1'b0;
	localparam logic [FRAME_LEN_W-1:0] MAX_PAYLOAD_RESET = 17'd65536;

	typedef struct packed {
		logic [1:0]             kind;
		logic [3:0]             frame_opcode;
		logic [FRAME_LEN_W-1:0] frame_length;
		logic [7:0]             data;
		logic                   last;
		logic [1:0]             error_code;
	} res_t;

endpackage

FILE: hw/rtl/wsfd_apb_regs.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer register block
// APB-style slave holding the payload length limit.
// ----------------------------------------------------------------------------
module wsfd_apb_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [2:0]                       paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output logic [wsfd_pkg::FRAME_LEN_W-1:0] max_payload
);

	logic [wsfd_pkg::FRAME_LEN_W-1:0] max_payload_q;
	logic                             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == wsfd_pkg::REG_MAX_PAYLOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= wsfd_pkg::MAX_PAYLOAD_RESET;
		end else if (wr_en) begin
			max_payload_q <= pwdata[wsfd_pkg::FRAME_LEN_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == wsfd_pkg::REG_MAX_PAYLOAD) begin
			prdata = 32'(max_payload_q);
		end
	end

	assign max_payload = max_payload_q;

endmodule

FILE: hw/rtl/wsfd_parser.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer parser
// Header state machine, length checks and payload unmasking for one byte.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_assert.svh"

module wsfd_parser #(
	parameter int LEN_W = 17
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [7:0]                       byte_s1,
	input  logic                             go,
	input  logic [wsfd_pkg::FRAME_LEN_W-1:0] max_payload,
	output logic                             res_v,
	output wsfd_pkg::res_t                   res
);

	localparam int CMP_W = (LEN_W > wsfd_pkg::FRAME_LEN_W) ? LEN_W : wsfd_pkg::FRAME_LEN_W;

	localparam logic [2:0] PH_B0   = 3'd0;
	localparam logic [2:0] PH_B1   = 3'd1;
	localparam logic [2:0] PH_EXT  = 3'd2;
	localparam logic [2:0] PH_KEY  = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;
	localparam logic [2:0] PH_DEAD = 3'd5;

	logic [2:0]       phase_q, phase_d;
	logic [3:0]       cnt_q, cnt_d;
	logic [3:0]       op_q, op_d;
	logic             mflag_q, mflag_d;
	logic [LEN_W-1:0] acc_q, acc_d;
	logic             ovf_q, ovf_d;
	logic [31:0]      key_q, key_d;
	logic [LEN_W-1:0] idx_q, idx_d;

	logic             len_done;
	logic             too_long;
	logic             fail;
	logic [1:0]       fail_code;
	logic [7:0]       key_byte;
	logic [6:0]       len7;

	assign len7     = byte_s1[6:0] & wsfd_pkg::HDR_LEN_MASK[6:0];
	assign key_byte = key_q[{~idx_q[1:0], 3'b000} +: 8];
	assign too_long = ovf_d || (CMP_W'(acc_d) > CMP_W'(max_payload));

	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		op_d      = op_q;
		mflag_d   = mflag_q;
		acc_d     = acc_q;
		ovf_d     = ovf_q;
		key_d     = key_q;
		idx_d     = idx_q;
		len_done  = 1'b0;
		fail      = 1'b0;
		fail_code = wsfd_pkg::ERR_RSV;
		res_v     = 1'b0;
		res.kind  = wsfd_pkg::KIND_START;
		res.data  = '0;
		res.last  = 1'b0;

		unique case (phase_q)
			PH_B0: begin
				acc_d   = '0;
				ovf_d   = 1'b0;
				idx_d   = '0;
				cnt_d   = '0;
				mflag_d = 1'b0;
				op_d    = byte_s1[3:0] & wsfd_pkg::HDR_OP_MASK[3:0];
				if ((byte_s1 & wsfd_pkg::HDR_RSV_MASK) != '0) begin
					fail      = 1'b1;
					fail_code = wsfd_pkg::ERR_RSV;
				end else if ((byte_s1 & wsfd_pkg::HDR_FIN_MASK) == '0) begin
					fail      = 1'b1;
					fail_code = wsfd_pkg::ERR_FIN;
				end else begin
					phase_d = PH_B1;
				end
			end
			PH_B1: begin
				mflag_d = byte_s1[7];
				if (len7 < wsfd_pkg::LEN7_EXT16) begin
					acc_d    = LEN_W'(len7);
					ovf_d    = 1'b0;
					len_done = 1'b1;
				end else begin
					cnt_d   = (len7 == wsfd_pkg::LEN7_EXT16) ? wsfd_pkg::EXT16_BYTES
						: wsfd_pkg::EXT64_BYTES;
					phase_d = PH_EXT;
				end
			end
			PH_EXT: begin
				// Any bit about to be shifted out of the accumulator means overflow.
				if ((acc_q >> (LEN_W - 8)) != '0) begin
					ovf_d = 1'b1;
				end
				acc_d    = LEN_W'({acc_q, byte_s1});
				cnt_d    = cnt_q - 4'd1;
				len_done = (cnt_d == '0);
			end
			PH_KEY: begin
				key_d = {key_q[23:0], byte_s1};
				cnt_d = cnt_q - 4'd1;
				if (cnt_d == '0) begin
					idx_d    = '0;
					res_v    = 1'b1;
					res.kind = wsfd_pkg::KIND_START;
					if (acc_q == '0) begin
						res.last = 1'b1;
						phase_d  = PH_B0;
					end else begin
						phase_d  = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				idx_d    = idx_q + LEN_W'(1);
				res_v    = 1'b1;
				res.kind = wsfd_pkg::KIND_BYTE;
				res.data = byte_s1 ^ key_byte;
				if (idx_d >= acc_q) begin
					res.last = 1'b1;
					phase_d  = PH_B0;
				end
			end
			default: begin
				// Dead after an error: bytes are dropped until reset.
			end
		endcase

		if (len_done) begin
			if (too_long) begin
				fail      = 1'b1;
				fail_code = wsfd_pkg::ERR_LONG;
			end else if (!mflag_d) begin
				fail      = 1'b1;
				fail_code = wsfd_pkg::ERR_UNMASKED;
			end else begin
				phase_d = PH_KEY;
				cnt_d   = wsfd_pkg::KEY_BYTES;
				key_d   = '0;
			end
		end

		if (fail) begin
			phase_d  = PH_DEAD;
			res_v    = 1'b1;
			res.kind = wsfd_pkg::KIND_ERROR;
			res.data = '0;
			res.last = 1'b0;
		end

		res.frame_opcode = op_d;
		res.frame_length = wsfd_pkg::FRAME_LEN_W'(acc_d);
		res.error_code   = fail ? fail_code : wsfd_pkg::ERR_RSV;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_B0;
			cnt_q   <= '0;
			op_q    <= '0;
			mflag_q <= 1'b0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			key_q   <= '0;
			idx_q   <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			op_q    <= op_d;
			mflag_q <= mflag_d;
			acc_q   <= acc_d;
			ovf_q   <= ovf_d;
			key_q   <= key_d;
			idx_q   <= idx_d;
		end
	end

	`WSFD_ASSERT(a_dead_silent, (phase_q == PH_DEAD) |-> !res_v)
	`WSFD_ASSERT(a_error_is_final, (go && res_v && res.kind == wsfd_pkg::KIND_ERROR) |=> (phase_q == PH_DEAD))
	`WSFD_ASSERT(a_index_in_frame, (phase_q == PH_DATA) |-> (idx_q < acc_q))
	`WSFD_ASSERT(a_key_count, (phase_q == PH_KEY) |-> (cnt_q != '0 && cnt_q <= wsfd_pkg::KEY_BYTES))

endmodule

FILE: hw/rtl/wsfd_out_reg.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_assert.svh"

module wsfd_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  wsfd_pkg::res_t res_in,
	output logic           space,
	output logic           res_valid,
	input  logic           res_ready,
	output wsfd_pkg::res_t res_q
);

	logic valid_q;

	// The register is free when empty or when its result leaves this cycle.
	assign space     = !valid_q || res_ready;
	assign res_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && space) begin
			res_q <= res_in;
		end
	end

	`WSFD_ASSERT(a_no_overwrite, (valid_q && !res_ready) |=> valid_q)
	`WSFD_ASSERT(a_stalled_holds, (valid_q && !res_ready) |=> $stable(res_q))
	`WSFD_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !valid_q)

endmodule

FILE: hw/rtl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Server-side client-frame parser: header, length checks and unmasking.
// ----------------------------------------------------------------------------
// The deframer takes one received byte per clock and returns at most one
// result per byte, so it sustains one byte per cycle while the result register
// is free. A byte is captured in an input register, parsed and unmasked by
// combinational logic, and written to the result register, which offers its
// result. Bytes that yield no result pass through even while a result waits
// downstream; a byte that yields a result waits in the input register until the
// result register is free. After an error the block drops every byte until
// reset. The payload limit is set through max_payload and may only be written
// while idle.
`include "websocket_frame_deframer_assert.svh"

module websocket_frame_deframer #(
	parameter int MAX_LENGTH_BITS = 17
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [2:0]                       paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	input  logic                             rx_valid,
	output logic                             rx_ready,
	input  logic [7:0]                       rx_byte,
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic [1:0]                       kind,
	output logic [3:0]                       frame_opcode,
	output logic [wsfd_pkg::FRAME_LEN_W-1:0] frame_length,
	output logic [7:0]                       data,
	output logic                             last,
	output logic [1:0]                       error_code
);

	logic                             valid_s1;
	logic [7:0]                       byte_s1;
	logic                             go;
	logic                             res_v;
	logic                             space;
	logic [wsfd_pkg::FRAME_LEN_W-1:0] max_payload;
	wsfd_pkg::res_t                   res;
	wsfd_pkg::res_t                   res_q;

	wsfd_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.max_payload (max_payload)
	);

	// A byte moves on unless it has a result and the result register is full.
	assign go       = valid_s1 && (!res_v || space);
	assign rx_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	wsfd_parser #(
		.LEN_W (MAX_LENGTH_BITS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_s1     (byte_s1),
		.go          (go),
		.max_payload (max_payload),
		.res_v       (res_v),
		.res         (res)
	);

	wsfd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (go && res_v),
		.res_in    (res),
		.space     (space),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_q     (res_q)
	);

	assign kind         = res_q.kind;
	assign frame_opcode = res_q.frame_opcode;
	assign frame_length = res_q.frame_length;
	assign data         = res_q.data;
	assign last         = res_q.last;
	assign error_code   = res_q.error_code;

	`WSFD_ASSERT(a_held_byte_blocks, (valid_s1 && !go) |-> !rx_ready)
	`WSFD_ASSERT(a_held_byte_waits, (valid_s1 && res_v && !space) |=> valid_s1 && $stable(byte_s1))
	`WSFD_ASSERT(a_result_needs_byte, (res_valid && !$past(res_valid) && $past(arst_n)) |-> $past(valid_s1))

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer regression
// Sends well-formed masked client frames with random content over several
// payload limits and handshake rates, checks every frame start and unmasked
// byte against a bit-accurate parser model, and ends on one rejected frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int LEN_W        = wsfd_pkg::FRAME_LEN_W;
	localparam int DRAIN_CYCLES = 12;
	localparam int PHASE_BYTES  = 150;

	localparam logic [2:0] ST_HDR0    = 3'd0;
	localparam logic [2:0] ST_HDR1    = 3'd1;
	localparam logic [2:0] ST_EXTLEN  = 3'd2;
	localparam logic [2:0] ST_KEY     = 3'd3;
	localparam logic [2:0] ST_PAYLOAD = 3'd4;
	localparam logic [2:0] ST_HALTED  = 3'd5;

	typedef enum int {ENC_SHORT, ENC_EXT16, ENC_EXT64} len_enc_t;

	// Parser model and the queue of results it predicts.
	class deframe_scoreboard;
		logic [2:0]       state;
		logic [3:0]       hdr_count;
		logic [3:0]       opcode;
		logic             masked;
		logic [LEN_W-1:0] len_accum;
		logic             len_overflow;
		logic [31:0]      key_word;
		logic [LEN_W-1:0] pay_index;
		logic [LEN_W-1:0] limit;
		wsfd_pkg::res_t   expected_q[$];
		int unsigned      mismatches;

		function new();
			state        = ST_HDR0;
			hdr_count    = '0;
			opcode       = '0;
			masked       = 1'b0;
			len_accum    = '0;
			len_overflow = 1'b0;
			key_word     = '0;
			pay_index    = '0;
			limit        = wsfd_pkg::MAX_PAYLOAD_RESET;
			mismatches   = 0;
		endfunction

		function void set_limit(logic [LEN_W-1:0] v);
			limit = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void push_result(logic [1:0] k, logic [7:0] d, logic l, logic [1:0] code);
			wsfd_pkg::res_t r;
			r.kind         = k;
			r.frame_opcode = opcode;
			r.frame_length = len_accum;
			r.data         = d;
			r.last         = l;
			r.error_code   = code;
			expected_q.push_back(r);
		endfunction

		function void raise_error(logic [1:0] code);
			state = ST_HALTED;
			push_result(wsfd_pkg::KIND_ERROR, 8'h00, 1'b0, code);
		endfunction

		function void length_complete();
			if (len_overflow || len_accum > limit) begin
				raise_error(wsfd_pkg::ERR_LONG);
			end else if (!masked) begin
				raise_error(wsfd_pkg::ERR_UNMASKED);
			end else begin
				state     = ST_KEY;
				hdr_count = wsfd_pkg::KEY_BYTES;
				key_word  = '0;
			end
		endfunction

		function void note_byte(logic [7:0] b);
			logic [7:0] kb;
			logic       fin;
			unique case (state)
				ST_HDR0: begin
					len_accum    = '0;
					len_overflow = 1'b0;
					pay_index    = '0;
					hdr_count    = '0;
					masked       = 1'b0;
					opcode       = b[3:0];
					if ((b & wsfd_pkg::HDR_RSV_MASK) != 8'h00)
						raise_error(wsfd_pkg::ERR_RSV);
					else if ((b & wsfd_pkg::HDR_FIN_MASK) == 8'h00)
						raise_error(wsfd_pkg::ERR_FIN);
					else
						state = ST_HDR1;
				end
				ST_HDR1: begin
					masked = b[7];
					if (b[6:0] < wsfd_pkg::LEN7_EXT16) begin
						len_accum    = LEN_W'(b[6:0]);
						len_overflow = 1'b0;
						length_complete();
					end else begin
						hdr_count = (b[6:0] == wsfd_pkg::LEN7_EXT16) ?
							wsfd_pkg::EXT16_BYTES : wsfd_pkg::EXT64_BYTES;
						state     = ST_EXTLEN;
					end
				end
				ST_EXTLEN: begin
					// Anything about to be shifted out of the length register is an overflow.
					if (len_accum[LEN_W-1:LEN_W-8] != '0)
						len_overflow = 1'b1;
					len_accum = {len_accum[LEN_W-9:0], b};
					hdr_count = hdr_count - 4'd1;
					if (hdr_count == 4'd0)
						length_complete();
				end
				ST_KEY: begin
					key_word  = {key_word[23:0], b};
					hdr_count = hdr_count - 4'd1;
					if (hdr_count == 4'd0) begin
						pay_index = '0;
						fin       = (len_accum == '0);
						state     = fin ? ST_HDR0 : ST_PAYLOAD;
						push_result(wsfd_pkg::KIND_START, 8'h00, fin, wsfd_pkg::ERR_RSV);
					end
				end
				ST_PAYLOAD: begin
					kb        = key_word[8*(3-int'(pay_index[1:0])) +: 8];
					pay_index = pay_index + 1'b1;
					fin       = (pay_index >= len_accum);
					if (fin)
						state = ST_HDR0;
					push_result(wsfd_pkg::KIND_BYTE, b ^ kb, fin, wsfd_pkg::ERR_RSV);
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(wsfd_pkg::res_t got);
			wsfd_pkg::res_t want;
			if (expected_q.size() == 0) begin
				$error("result with no request pending: kind %0d", got.kind);
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("frame_opcode", want.frame_opcode, got.frame_opcode);
			compare_field("frame_length", want.frame_length, got.frame_length);
			compare_field("data", want.data, got.data);
			compare_field("last", want.last, got.last);
			compare_field("error_code", want.error_code, got.error_code);
		endfunction
	endclass

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b1;
	logic             psel      = 1'b0;
	logic             penable   = 1'b0;
	logic             pwrite    = 1'b0;
	logic [2:0]       paddr     = '0;
	logic [31:0]      pwdata    = '0;
	logic [31:0]      prdata;
	logic             pready;
	logic             rx_valid  = 1'b0;
	logic             rx_ready;
	logic [7:0]       rx_byte   = '0;
	logic             res_valid;
	logic             res_ready = 1'b0;
	logic [1:0]       kind;
	logic [3:0]       frame_opcode;
	logic [LEN_W-1:0] frame_length;
	logic [7:0]       data;
	logic             last;
	logic [1:0]       error_code;

	deframe_scoreboard sb;
	int unsigned       rx_gap_pct    = 0;
	int unsigned       res_stall_pct = 0;
	int unsigned       hold_cycles   = 0;
	int unsigned       bytes_sent    = 0;
	logic [LEN_W-1:0]  cur_limit     = wsfd_pkg::MAX_PAYLOAD_RESET;

	websocket_frame_deframer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.rx_valid     (rx_valid),
		.rx_ready     (rx_ready),
		.rx_byte      (rx_byte),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.kind         (kind),
		.frame_opcode (frame_opcode),
		.frame_length (frame_length),
		.data         (data),
		.last         (last),
		.error_code   (error_code)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("websocket_frame_deframer regression: fail");
		$finish;
	end

	// Result side: random stalls, or a long hold-off while hold_cycles runs down.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			res_ready <= 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			res_ready <= ($urandom_range(99) >= res_stall_pct);
		end
	end

	// Handshakes are sampled before this edge's updates land.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_valid && rx_ready)
				sb.note_byte(rx_byte);
			if (res_valid && res_ready)
				sb.check_result({kind, frame_opcode, frame_length, data, last, error_code});
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < rx_gap_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!rx_ready);
		bytes_sent++;
	endtask

	// The payload limit may only change with nothing in flight.
	task automatic write_max_payload(input logic [LEN_W-1:0] v);
		rx_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {wsfd_pkg::REG_MAX_PAYLOAD, 2'b00};
		pwdata  <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_limit(v);
		cur_limit = v;
	endtask

	task automatic send_header(input logic [3:0] op, input logic [63:0] len,
	                           input len_enc_t enc, input logic mask_bit);
		send_byte(wsfd_pkg::HDR_FIN_MASK | {4'h0, op});
		case (enc)
			ENC_SHORT: send_byte({mask_bit, len[6:0]});
			ENC_EXT16: begin
				send_byte({mask_bit, wsfd_pkg::LEN7_EXT16});
				send_byte(len[15:8]);
				send_byte(len[7:0]);
			end
			default: begin
				send_byte({mask_bit, wsfd_pkg::LEN7_EXT64});
				for (int i = 7; i >= 0; i--)
					send_byte(len[8*i +: 8]);
			end
		endcase
	endtask

	task automatic send_body(input logic [31:0] key, input int unsigned len);
		for (int i = 0; i < 4; i++)
			send_byte(key[8*(3-i) +: 8]);
		for (int unsigned i = 0; i < len; i++)
			send_byte(8'($urandom));
	endtask

	task automatic send_frame(input logic [3:0] op, input int unsigned len,
	                          input len_enc_t enc, input logic [31:0] key);
		send_header(op, 64'(len), enc, 1'b1);
		send_body(key, len);
	endtask

	function automatic len_enc_t pick_encoding(int unsigned len);
		int unsigned r;
		r = $urandom_range(99);
		if (len <= 125)
			return (r < 70) ? ENC_SHORT : (r < 88) ? ENC_EXT16 : ENC_EXT64;
		if (len <= 65535)
			return (r < 75) ? ENC_EXT16 : ENC_EXT64;
		return ENC_EXT64;
	endfunction

	// Mostly short payloads; now and then a length right at the limit.
	function automatic int unsigned pick_length(int unsigned lim);
		int unsigned r;
		int unsigned cap;
		r   = $urandom_range(99);
		cap = (r < 70) ? 20 : (r < 95) ? 300 : 600;
		if (cap > lim)
			cap = lim;
		if (lim <= 600 && $urandom_range(19) == 0)
			return lim;
		return $urandom_range(cap);
	endfunction

	task automatic random_frame();
		int unsigned len;
		len = pick_length(cur_limit);
		send_frame(4'($urandom), len, pick_encoding(len), $urandom);
	endtask

	// One rejected frame ends the stimulus, since the error holds until reset.
	task automatic send_bad_frame();
		logic [1:0]  which;
		logic [63:0] len;
		which = 2'($urandom_range(3));
		case (which)
			wsfd_pkg::ERR_RSV:
				send_byte({1'($urandom), 3'($urandom_range(7, 1)), 4'($urandom)});
			wsfd_pkg::ERR_FIN:
				send_byte({4'h0, 4'($urandom)});
			wsfd_pkg::ERR_LONG: begin
				if ($urandom_range(1)) begin
					len = 64'($urandom_range(65535, int'(cur_limit) + 1));
					send_header(4'($urandom), len, ENC_EXT16, 1'($urandom));
				end else begin
					len = {32'($urandom), 32'($urandom)} | 64'h1_0000_0000;
					send_header(4'($urandom), len, ENC_EXT64, 1'($urandom));
				end
			end
			default: begin
				len = 64'(pick_length(cur_limit));
				send_header(4'($urandom), len, pick_encoding(int'(len)), 1'b0);
			end
		endcase
		repeat (10) send_byte(8'($urandom));
	endtask

	initial begin
		int unsigned phase_start;
		logic [LEN_W-1:0] phase_limit [4];
		int unsigned gap_pct [4];
		int unsigned stall_pct [4];

		arst_n <= 1'b0;
		sb = new();
		phase_limit = '{wsfd_pkg::MAX_PAYLOAD_RESET, '0, LEN_W'($urandom_range(65535, 1)),
		                LEN_W'($urandom_range(500, 126))};
		gap_pct   = '{0, 52, 0, 17};
		stall_pct = '{0, 0, 52, 17};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames: empty, single byte, index wrap, length encodings and the
		// largest payload the limit allows.
		send_frame(4'h0, 0, ENC_SHORT, 32'h0000_0000);
		send_frame(4'hf, 1, ENC_SHORT, 32'hffff_ffff);
		send_frame(4'h1, 5, ENC_EXT16, $urandom);
		send_frame(4'h2, 125, ENC_SHORT, $urandom);
		send_frame(4'h8, 126, ENC_EXT16, $urandom);
		send_frame(4'h9, 200, ENC_EXT64, $urandom);
		write_max_payload(LEN_W'(37));
		send_frame(4'h1, 37, ENC_SHORT, $urandom);
		send_frame(4'h7, 0, ENC_EXT64, $urandom);

		for (int p = 0; p < 4; p++) begin
			write_max_payload(phase_limit[p]);
			rx_gap_pct    = gap_pct[p];
			res_stall_pct = stall_pct[p];
			if (p == 0) begin
				// Hold results back long enough for the block to stall its input.
				hold_cycles = 300;
				send_frame(4'h2, 200, ENC_EXT16, $urandom);
			end
			phase_start = bytes_sent;
			while (bytes_sent < phase_start + PHASE_BYTES)
				random_frame();
		end

		send_bad_frame();
		rx_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("websocket_frame_deframer regression: pass");
		else
			$display("websocket_frame_deframer regression: fail");
		$finish;
	end

endmodule
